// ===== hdl/cscalm_pkg.sv =====
package cscalm_pkg;

  localparam int MAX_POINTS_DEF  = 256;
  localparam int COORD_BITS_DEF  = 12;

  localparam int POINT_W = 12;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 16;
  localparam int HOLD_W  = 17;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [HOLD_W-1:0] HOLD_MAX   = 17'h1FFFF;
  localparam logic [CFG_W-1:0]  HOLD_RESET = 16'd70;

  localparam logic [APB_AW-1:0] REG_MAX_HOLD = 3'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_POINT = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    PH_NONE  = 3'b001,
    PH_REF   = 3'b010,
    PH_LATER = 3'b100
  } phase_t;

  // microcode
  localparam int STEP_W = 3;

  localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] ST_DISP  = 3'd1;
  localparam logic [STEP_W-1:0] ST_START = 3'd2;
  localparam logic [STEP_W-1:0] ST_REFWR = 3'd3;
  localparam logic [STEP_W-1:0] ST_DROP  = 3'd4;
  localparam logic [STEP_W-1:0] ST_SCAN0 = 3'd5;
  localparam logic [STEP_W-1:0] ST_SCAN  = 3'd6;
  localparam logic [STEP_W-1:0] ST_EVAL  = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_REFWR,
    OP_DROP,
    OP_SCAN0,
    OP_SCAN,
    OP_EVAL
  } op_t;

  typedef enum logic [2:0] {
    C_JUMP,
    C_ACCEPT,
    C_DISPATCH,
    C_LOOP,
    C_OUTFREE
  } cond_t;

  typedef struct packed {
    logic              in_rdy;
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic              in_valid;
    logic              out_free;
    logic              scan_busy;
    logic [STEP_W-1:0] disp_step;
  } seq_stat_t;

  typedef struct packed {
    logic in_rdy;
    logic fire;
    op_t  op;
  } seq_ctrl_t;

  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    unique case (step)
      ST_IDLE:  w = '{1'b1, OP_LOAD,  C_ACCEPT,   ST_DISP};
      ST_DISP:  w = '{1'b0, OP_NONE,  C_DISPATCH, ST_IDLE};
      ST_START: w = '{1'b0, OP_START, C_JUMP,     ST_IDLE};
      ST_REFWR: w = '{1'b0, OP_REFWR, C_JUMP,     ST_IDLE};
      ST_DROP:  w = '{1'b0, OP_DROP,  C_JUMP,     ST_IDLE};
      ST_SCAN0: w = '{1'b0, OP_SCAN0, C_JUMP,     ST_SCAN};
      ST_SCAN:  w = '{1'b0, OP_SCAN,  C_LOOP,     ST_IDLE};
      ST_EVAL:  w = '{1'b0, OP_EVAL,  C_OUTFREE,  ST_IDLE};
      default:  w = '{1'b1, OP_LOAD,  C_ACCEPT,   ST_DISP};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/cscalm_ram.sv =====
module cscalm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/cscalm_seq.sv =====
module cscalm_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  cscalm_pkg::seq_stat_t stat,
  output cscalm_pkg::seq_ctrl_t ctrl
);
  import cscalm_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ucw_t              cw;
  logic              fire;

  always_comb begin
    cw      = ucode(pc);
    fire    = 1'b1;
    pc_next = pc;
    unique case (cw.cond)
      C_JUMP: pc_next = cw.target;
      C_ACCEPT: begin
        fire = stat.in_valid;
        if (stat.in_valid) pc_next = cw.target;
      end
      C_DISPATCH: pc_next = stat.disp_step;
      C_LOOP: begin
        if (!stat.scan_busy) pc_next = cw.target;
      end
      C_OUTFREE: begin
        fire = stat.out_free;
        if (stat.out_free) pc_next = cw.target;
      end
      default: pc_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.in_rdy = cw.in_rdy;
  assign ctrl.fire   = fire;
  assign ctrl.op     = cw.op;

endmodule

// ===== hdl/corner_set_change_alarm_top.sv =====
// channel | handshake           | payload
// input   | in_valid, in_ready  | command, point_x, point_y
// result  | out_valid, out_ready| changed, same_as_reference, overflow
// config  | APB write/read      | max_hold_frames at byte address 0
//
// Every item is loaded and dispatched; frame start, reference point, dropped point then
// take an action step; ignored items stop there. A later-frame point sets up a scan of
// the reference, one RAM read per cycle. Frame end waits for a held result to be taken.
// Reset is synchronous; the reference RAM is not cleared.
// in_ready is high only while the sequencer sits in its idle step.
module corner_set_change_alarm_top #(
  parameter int MAX_POINTS = cscalm_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cscalm_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cscalm_pkg::CMD_W-1:0]   command,
  input  logic [cscalm_pkg::POINT_W-1:0] point_x,
  input  logic [cscalm_pkg::POINT_W-1:0] point_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           changed,
  output logic                           same_as_reference,
  output logic                           overflow,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cscalm_pkg::APB_AW-1:0]  paddr,
  input  logic [cscalm_pkg::APB_DW-1:0]  pwdata,
  output logic [cscalm_pkg::APB_DW-1:0]  prdata,
  output logic                           pready
);
  import cscalm_pkg::*;

  localparam int CW     = (COORD_BITS < POINT_W) ? COORD_BITS : POINT_W;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PAIR_W = $clog2(MAX_POINTS * MAX_POINTS + 1);

  seq_stat_t stat;
  seq_ctrl_t ctrl;

  logic [CMD_W-1:0]  cmd_q;
  logic [CW-1:0]     x_q;
  logic [CW-1:0]     y_q;
  phase_t            phase;
  logic [CNT_W-1:0]  ref_count;
  logic [CNT_W-1:0]  cur_count;
  logic [PAIR_W-1:0] pair;
  logic [CNT_W-1:0]  rd_idx;
  logic              pend;
  logic              alarm;
  logic [HOLD_W-1:0] hold;
  logic              dropped;
  logic [CFG_W-1:0]  max_hold;

  logic              ref_full;
  logic              cur_full;
  logic              scan_busy;
  logic              ram_we;
  logic              ram_re;
  logic [2*CW-1:0]   rdata;
  logic              hit;
  logic [STEP_W-1:0] disp_step;

  logic              same_w;
  logic              changed_w;
  logic              alarm_next;
  logic [HOLD_W-1:0] hold_next;

  assign ref_full  = (ref_count == CNT_W'(MAX_POINTS));
  assign cur_full  = (cur_count == CNT_W'(MAX_POINTS));
  assign scan_busy = (rd_idx < ref_count);
  assign hit       = (rdata == {x_q, y_q});

  always_comb begin
    unique case (cmd_q)
      CMD_START: disp_step = ST_START;
      CMD_POINT: begin
        if (phase == PH_REF) begin
          disp_step = ref_full ? ST_DROP : ST_REFWR;
        end else if (phase == PH_LATER) begin
          disp_step = cur_full ? ST_DROP : ST_SCAN0;
        end else begin
          disp_step = ST_IDLE;
        end
      end
      CMD_END: disp_step = ST_EVAL;
      default: disp_step = ST_IDLE;
    endcase
  end

  assign stat.in_valid  = in_valid;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.scan_busy = scan_busy;
  assign stat.disp_step = disp_step;

  cscalm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign in_ready = ctrl.in_rdy;

  assign ram_we = ctrl.fire && (ctrl.op == OP_REFWR);
  assign ram_re = (ctrl.op == OP_SCAN) && scan_busy;

  cscalm_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_POINTS),
    .AW    (IDX_W)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ref_count[IDX_W-1:0]),
    .wdata ({x_q, y_q}),
    .re    (ram_re),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    same_w     = (phase == PH_LATER) && (ref_count == cur_count) &&
                 (pair == PAIR_W'(cur_count));
    changed_w  = 1'b0;
    alarm_next = alarm;
    hold_next  = hold;
    if (phase == PH_LATER) begin
      if (!same_w) begin
        changed_w  = 1'b1;
        alarm_next = 1'b1;
        hold_next  = '0;
      end else if (alarm) begin
        if (hold < HOLD_W'(max_hold)) begin
          changed_w = 1'b1;
        end else begin
          alarm_next = 1'b0;
        end
        if (hold < HOLD_MAX) hold_next = hold + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NONE;
      ref_count <= '0;
      cur_count <= '0;
      pair      <= '0;
      rd_idx    <= '0;
      pend      <= 1'b0;
      alarm     <= 1'b0;
      hold      <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (ctrl.fire && ctrl.op == OP_EVAL) || (out_valid && !out_ready);
      if (ctrl.fire) begin
        case (ctrl.op)
          OP_START: begin
            if (phase == PH_NONE) begin
              phase <= PH_REF;
            end else begin
              phase     <= PH_LATER;
              cur_count <= '0;
              pair      <= '0;
            end
            dropped <= 1'b0;
          end
          OP_REFWR: ref_count <= ref_count + 1'b1;
          OP_DROP:  dropped <= 1'b1;
          OP_SCAN0: begin
            cur_count <= cur_count + 1'b1;
            rd_idx    <= '0;
            pend      <= 1'b0;
          end
          OP_SCAN: begin
            pend <= scan_busy;
            if (scan_busy) rd_idx <= rd_idx + 1'b1;
            if (pend && hit) pair <= pair + 1'b1;
          end
          OP_EVAL: begin
            alarm <= alarm_next;
            hold  <= hold_next;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.op == OP_LOAD) begin
      cmd_q <= command;
      x_q   <= point_x[CW-1:0];
      y_q   <= point_y[CW-1:0];
    end
    if (ctrl.fire && ctrl.op == OP_EVAL) begin
      changed           <= changed_w;
      same_as_reference <= same_w;
      overflow          <= dropped;
    end
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      max_hold <= HOLD_RESET;
    end else if (psel && penable && pwrite && paddr == REG_MAX_HOLD) begin
      max_hold <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_HOLD) ? APB_DW'(max_hold) : '0;

endmodule

// ===== hdl/cscalm_chk.sv =====
module cscalm_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic changed,
  input logic same_as_reference,
  input logic overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(changed) &&
      $stable(same_as_reference) && $stable(overflow))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too soon after a transfer");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind corner_set_change_alarm_top cscalm_chk u_chk (.*);
